// ----- src/pcmf_pkg.sv -----
package pcmf_pkg;

    // default number of command sources
    localparam int SOURCES_DEF = 8;

    // configuration register widths and reset values
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_W      = 4;
    localparam int MID_W      = 12;
    localparam int AGE_W      = 16;
    // width used to compare source counts against each other
    localparam int CMP_W      = NUM_W + 1;

    localparam logic [AGE_W-1:0] MAX_AGE_RST   = 16'd2000;
    localparam logic [MID_W-1:0] STEER_MID_RST = 12'd1500;
    localparam logic [NUM_W-1:0] NUM_SRC_RST   = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SRC   = 2'd2;

    // held actuator values, signed thousandths
    localparam int HELD_W = 11;
    localparam logic signed [15:0] CMD_MAX = 16'sd1000;
    localparam logic signed [15:0] CMD_MIN = -16'sd1000;

    // operation codes
    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_TICK  = 2'd1,
        OP_EMERG = 2'd2
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FRAME
    } state_t;

    // input word
    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         source;
        logic [31:0]        stamp;
        logic signed [15:0] cmd_throttle;
        logic signed [15:0] cmd_steering;
        logic [31:0]        now;
        logic signed [31:0] emergency_level;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } out_word_t;

    // one stored command
    typedef struct packed {
        logic [31:0]        stamp;
        logic signed [15:0] throttle;
        logic signed [15:0] steering;
    } cmd_entry_t;

    // per-source qualification from the compare unit
    typedef struct packed {
        logic fresh;
        logic thr_ok;
        logic steer_ok;
    } scan_res_t;

    // frame request from the sequencer
    typedef struct packed {
        logic                     start;
        logic signed [HELD_W-1:0] throttle;
        logic signed [HELD_W-1:0] steering;
        logic [MID_W-1:0]         steer_mid;
    } frm_cmd_t;

endpackage

// ----- src/pcmf_cmd_table.sv -----
module pcmf_cmd_table
    import pcmf_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEF,
    parameter int SRC_W   = (SOURCES > 1) ? $clog2(SOURCES) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [SRC_W-1:0] wr_idx,
    input  cmd_entry_t       wr_entry,
    input  logic [SRC_W-1:0] rd_idx,
    output cmd_entry_t       rd_entry
);

    cmd_entry_t entry_reg [SOURCES];

    // latest command per source, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SOURCES; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (wr_en) begin
            entry_reg[wr_idx] <= wr_entry;
        end
    end

    // scan read port
    assign rd_entry = entry_reg[rd_idx];

endmodule

// ----- src/pcmf_scan_unit.sv -----
module pcmf_scan_unit
    import pcmf_pkg::*;
(
    input  logic [31:0]      now,
    input  logic [AGE_W-1:0] max_age,
    input  cmd_entry_t       entry,
    output scan_res_t        res
);

    logic [31:0] age;

    // wrapping age of the command and freshness compare
    assign age       = now - entry.stamp;
    assign res.fresh = age < {16'd0, max_age};

    // range checks on the stored values
    assign res.thr_ok   = (entry.throttle >= CMD_MIN) && (entry.throttle <= CMD_MAX);
    assign res.steer_ok = (entry.steering >= CMD_MIN) && (entry.steering <= CMD_MAX);

endmodule

// ----- src/pcmf_framer.sv -----
module pcmf_framer
    import pcmf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  frm_cmd_t  cmd,
    output logic      busy,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam logic [2:0] POS_HDR   = 3'd0;
    localparam logic [2:0] POS_SPD_L = 3'd1;
    localparam logic [2:0] POS_SPD_H = 3'd2;
    localparam logic [2:0] POS_ANG_L = 3'd3;
    localparam logic [2:0] POS_ANG_H = 3'd4;
    localparam logic [2:0] POS_SUM   = 3'd5;
    localparam logic [2:0] POS_FTR   = 3'd6;

    localparam logic [7:0]  HDR_BYTE  = 8'hAA;
    localparam logic [7:0]  FTR_BYTE  = 8'h55;
    localparam logic [15:0] SPD_NEUTR = 16'd1500;

    logic        busy_reg;
    logic [2:0]  cnt_reg;
    logic [15:0] speed_reg;
    logic [15:0] angle_reg;
    logic        valid_reg;
    out_word_t   data_reg;

    logic        load;
    logic [7:0]  sum;
    logic [7:0]  sel_byte;
    logic [15:0] speed_next;
    logic [15:0] angle_next;

    // pulse widths from the selected values
    assign speed_next = SPD_NEUTR + {{(16-HELD_W){cmd.throttle[HELD_W-1]}}, cmd.throttle};
    assign angle_next = {{(16-MID_W){1'b0}}, cmd.steer_mid}
                        - {{(16-HELD_W){cmd.steering[HELD_W-1]}}, cmd.steering};

    // checksum over the four payload bytes
    assign sum = speed_reg[7:0] + speed_reg[15:8] + angle_reg[7:0] + angle_reg[15:8];

    // byte for the current position
    always_comb begin
        case (cnt_reg)
            POS_HDR:   sel_byte = HDR_BYTE;
            POS_SPD_L: sel_byte = speed_reg[7:0];
            POS_SPD_H: sel_byte = speed_reg[15:8];
            POS_ANG_L: sel_byte = angle_reg[7:0];
            POS_ANG_H: sel_byte = angle_reg[15:8];
            POS_SUM:   sel_byte = sum;
            POS_FTR:   sel_byte = FTR_BYTE;
            default:   sel_byte = FTR_BYTE;
        endcase
    end

    // next byte moves into the output register when it is free
    assign load = busy_reg && (!valid_reg || m_ready);

    // byte sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= POS_HDR;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= POS_HDR;
        end else if (load) begin
            busy_reg <= (cnt_reg != POS_FTR);
            cnt_reg  <= cnt_reg + 3'd1;
        end
    end

    // frame values captured at start
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            speed_reg <= speed_next;
            angle_reg <= angle_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.frame_byte <= sel_byte;
            data_reg.last_byte  <= (cnt_reg == POS_FTR);
        end
    end

    assign busy    = busy_reg;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // a new frame never starts over one in progress
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg)
        else $error("frame start while framer busy");

    // the footer byte is the last one loaded for a frame
    a_footer_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && cnt_reg == POS_FTR) |=> !busy_reg && valid_reg && data_reg.last_byte)
        else $error("footer byte not ending the frame");

endmodule

// ----- src/priority_command_mux_framer_unit.sv -----
// Priority command multiplexer and actuator framer. A store word writes the
// command of one source (ignored at or above num_sources), a set-emergency word
// writes the emergency level; neither gives an output. A tick word with a
// positive emergency level sends a neutral frame; otherwise one shared age
// comparator with two range checks walks the sources from 0 upward, one per
// cycle, and the first fresh in-range value of each actuator is held. A tick
// scans min(num_sources, SOURCES) sources, then sends seven output words
// through a one-byte output register; no new input word is taken until the
// framer has loaded the last of them.
// Configuration registers: 0 max_age, 1 steer_middle, 2 num_sources.
module priority_command_mux_framer_unit
    import pcmf_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SRC_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int CNT_W = $clog2(SOURCES + 1);
    localparam logic [CMP_W-1:0] SRC_LIMIT = CMP_W'(SOURCES);

    state_t state_reg;
    state_t state_next;

    logic [AGE_W-1:0]         max_age_reg;
    logic [MID_W-1:0]         steer_mid_reg;
    logic [NUM_W-1:0]         num_src_reg;
    logic signed [31:0]       emerg_reg;
    logic [31:0]              now_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic                     got_thr_reg;
    logic                     got_steer_reg;
    logic signed [HELD_W-1:0] held_thr_reg;
    logic signed [HELD_W-1:0] held_steer_reg;

    logic             accept;
    logic             emerg_on;
    logic [CMP_W-1:0] active_n;
    logic [CMP_W-1:0] src_ext;
    logic             store_ok;
    logic             scan_end;
    logic             scan_step;
    cmd_entry_t       wr_entry;
    cmd_entry_t       rd_entry;
    scan_res_t        scan_res;
    frm_cmd_t         frm_cmd;
    logic             frm_busy;

    assign accept   = s_valid && s_ready;
    assign emerg_on = !emerg_reg[31] && (emerg_reg != 32'sd0);

    // number of sources in use, limited to the table size
    assign active_n = ({1'b0, num_src_reg} > SRC_LIMIT) ? SRC_LIMIT : {1'b0, num_src_reg};
    assign src_ext  = CMP_W'(s_data.source);
    assign store_ok = accept && (s_data.operation == OP_STORE) && (src_ext < active_n);

    assign scan_end  = CMP_W'(idx_reg) >= active_n;
    assign scan_step = (state_reg == ST_SCAN) && !scan_end;

    // command table
    assign wr_entry.stamp    = s_data.stamp;
    assign wr_entry.throttle = s_data.cmd_throttle;
    assign wr_entry.steering = s_data.cmd_steering;

    pcmf_cmd_table #(
        .SOURCES (SOURCES),
        .SRC_W   (SRC_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (store_ok),
        .wr_idx   (src_ext[SRC_W-1:0]),
        .wr_entry (wr_entry),
        .rd_idx   (idx_reg[SRC_W-1:0]),
        .rd_entry (rd_entry)
    );

    // shared age and range compare
    pcmf_scan_unit u_scan (
        .now     (now_reg),
        .max_age (max_age_reg),
        .entry   (rd_entry),
        .res     (scan_res)
    );

    // frame builder and output register
    pcmf_framer u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (frm_cmd),
        .busy    (frm_busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.operation == OP_TICK) begin
                    state_next = emerg_on ? ST_FRAME : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_FRAME;
                end
            end
            ST_FRAME: begin
                if (!frm_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready           = 1'b0;
        frm_cmd.start     = 1'b0;
        frm_cmd.throttle  = held_thr_reg;
        frm_cmd.steering  = held_steer_reg;
        frm_cmd.steer_mid = steer_mid_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready          = 1'b1;
                frm_cmd.start    = s_valid && (s_data.operation == OP_TICK) && emerg_on;
                frm_cmd.throttle = '0;
                frm_cmd.steering = '0;
            end
            ST_SCAN: begin
                frm_cmd.start = scan_end;
            end
            ST_FRAME: begin
                frm_cmd.start = 1'b0;
            end
            default: begin
                frm_cmd.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_age_reg   <= MAX_AGE_RST;
            steer_mid_reg <= STEER_MID_RST;
            num_src_reg   <= NUM_SRC_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_AGE:   max_age_reg   <= cfg_wdata[AGE_W-1:0];
                CFG_STEER_MID: steer_mid_reg <= cfg_wdata[MID_W-1:0];
                CFG_NUM_SRC:   num_src_reg   <= cfg_wdata[NUM_W-1:0];
                default:       max_age_reg   <= max_age_reg;
            endcase
        end
    end

    // emergency level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emerg_reg <= '0;
        end else if (accept && s_data.operation == OP_EMERG) begin
            emerg_reg <= s_data.emergency_level;
        end
    end

    // tick time
    always_ff @(posedge aclk) begin
        if (accept && s_data.operation == OP_TICK) begin
            now_reg <= s_data.now;
        end
    end

    // scan index and found flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            got_thr_reg   <= 1'b0;
            got_steer_reg <= 1'b0;
        end else if (accept && s_data.operation == OP_TICK) begin
            idx_reg       <= '0;
            got_thr_reg   <= 1'b0;
            got_steer_reg <= 1'b0;
        end else if (scan_step) begin
            idx_reg <= CNT_W'(idx_reg + 1'b1);
            if (scan_res.fresh && scan_res.thr_ok) begin
                got_thr_reg <= 1'b1;
            end
            if (scan_res.fresh && scan_res.steer_ok) begin
                got_steer_reg <= 1'b1;
            end
        end
    end

    // held actuator values take the first qualifying source
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_thr_reg   <= '0;
            held_steer_reg <= '0;
        end else if (scan_step && scan_res.fresh) begin
            if (!got_thr_reg && scan_res.thr_ok) begin
                held_thr_reg <= rd_entry.throttle[HELD_W-1:0];
            end
            if (!got_steer_reg && scan_res.steer_ok) begin
                held_steer_reg <= rd_entry.steering[HELD_W-1:0];
            end
        end
    end

    // the framer is quiet whenever the sequencer waits for a word
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !frm_busy)
        else $error("framer busy in idle");

    // held values stay within the actuator range
    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_thr_reg >= -11'sd1000) && (held_thr_reg <= 11'sd1000)
        && (held_steer_reg >= -11'sd1000) && (held_steer_reg <= 11'sd1000))
        else $error("held value out of range");

    // a scan never runs past the sources in use
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> CMP_W'(idx_reg) <= active_n)
        else $error("scan index past active sources");

    // a frame follows every emergency tick
    a_tick_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.operation == OP_TICK && emerg_on) |=> frm_busy)
        else $error("emergency tick did not start a frame");

endmodule
